// ----- hw/rtl/multi_circle_overlap_test_assert.svh -----
// Assertion macros for the multi-circle overlap test.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef MULTI_CIRCLE_OVERLAP_TEST_ASSERT_SVH
`define MULTI_CIRCLE_OVERLAP_TEST_ASSERT_SVH
`ifndef SYNTHESIS
`define MCOT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MCOT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MCOT_ASSERT_NOW(label, ante, cons)
`define MCOT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/mcot_pkg.sv -----
// Shared constants and types for the multi-circle overlap test.
// No dependencies.
package mcot_pkg;
  localparam int MAX_CIRCLES_DEF = 8;
  localparam int MUL_W  = 28;
  localparam int PROD_W = 2 * MUL_W;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic signed [14:0] COORD_LIM = 15'sd8192;
  localparam logic [13:0] RAD_MIN = 14'd16;
  localparam logic [13:0] RAD_MAX = 14'd8192;
endpackage

// ----- hw/rtl/mcot_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on mcot_pkg for the operand and product widths.
module mcot_mul (
  input  logic                                clk,
  input  logic signed [mcot_pkg::MUL_W-1:0]  a,
  input  logic signed [mcot_pkg::MUL_W-1:0]  b,
  output logic signed [mcot_pkg::PROD_W-1:0] prod
);
  import mcot_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end
endmodule

// ----- hw/rtl/multi_circle_overlap_test.sv -----
// Multi-circle overlap test: top level.
// Depends on mcot_pkg, mcot_mul and multi_circle_overlap_test_assert.svh.
//
// Circles are held in a small synchronous memory. A query reads one stored
// circle at a time and runs ten products through one shared multiplier; the
// walk over the stored circles stops at the first hit, and a query on an empty
// table goes straight to the result. One item is worked on at a time; a new
// item is taken while the previous result waits.
module multi_circle_overlap_test #(
  parameter int MAX_CIRCLES = mcot_pkg::MAX_CIRCLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [14:0] circle_offset_x,
  input  logic signed [14:0] circle_offset_y,
  input  logic [13:0]        circle_radius,
  input  logic signed [19:0] center_x,
  input  logic signed [19:0] center_y,
  input  logic signed [15:0] rot_cos,
  input  logic signed [15:0] rot_sin,
  input  logic [11:0]        scale,
  input  logic signed [19:0] probe_x,
  input  logic signed [19:0] probe_y,
  input  logic signed [13:0] probe_radius,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               overlap,
  output logic [3:0]         circle_count
);
  import mcot_pkg::*;

  localparam int IDX_W = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
  localparam int CNT_W = $clog2(MAX_CIRCLES + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_MUL, ST_DONE} state_t;

  typedef struct packed {
    logic signed [14:0] x;
    logic signed [14:0] y;
    logic [13:0]        r;
  } circ_t;

  state_t state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] idx;
  logic [3:0]       step;
  logic             hit;
  logic [13:0]      pad;

  circ_t mem [MAX_CIRCLES];
  circ_t ent;

  // Query operands held for the whole walk.
  logic signed [19:0] cx, cy, px, py;
  logic signed [15:0] cs, sn;
  logic [11:0]        sc;
  logic [14:0]        extra;

  logic signed [26:0] sx, sy;
  logic [25:0]        rr;
  logic signed [56:0] acc;
  logic signed [20:0] qx, qy;
  logic signed [22:0] dx, dy;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  logic in_xfer, out_free, cfg_wr, last;
  circ_t new_circ;

  function automatic logic signed [20:0] round_q4(input logic signed [56:0] v);
    logic signed [56:0] t;
    t = v + 57'sd2097152;
    return t[42:22];
  endfunction

  assign pready   = 1'b1;
  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign cfg_wr   = psel && penable && pwrite && pready && !paddr[2];
  assign prdata   = paddr[2] ? 32'd0 : 32'(pad);
  assign last     = (CNT_W'(idx) + CNT_W'(1)) == count;

  always_comb begin
    new_circ.x = (circle_offset_x > COORD_LIM) ? COORD_LIM :
                 (circle_offset_x < -COORD_LIM) ? -COORD_LIM : circle_offset_x;
    new_circ.y = (circle_offset_y > COORD_LIM) ? COORD_LIM :
                 (circle_offset_y < -COORD_LIM) ? -COORD_LIM : circle_offset_y;
    new_circ.r = (circle_radius < RAD_MIN) ? RAD_MIN :
                 (circle_radius > RAD_MAX) ? RAD_MAX : circle_radius;
  end

  always_ff @(posedge clk) begin
    if (in_xfer && op_t'(opcode) == OP_APPEND && count < CNT_W'(MAX_CIRCLES)) begin
      mem[count[IDX_W-1:0]] <= new_circ;
    end
    ent <= mem[idx];
  end

  // Operand selection for the shared multiplier, at most one product per step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step)
      4'd0:  begin mul_a = MUL_W'(ent.x); mul_b = MUL_W'(signed'({1'b0, sc})); end
      4'd1:  begin mul_a = MUL_W'(ent.y); mul_b = MUL_W'(signed'({1'b0, sc})); end
      4'd2:  begin
        mul_a = MUL_W'(signed'({1'b0, ent.r}));
        mul_b = MUL_W'(signed'({1'b0, sc}));
      end
      4'd3:  begin mul_a = MUL_W'(sx); mul_b = MUL_W'(cs); end
      4'd4:  begin mul_a = MUL_W'(sy); mul_b = MUL_W'(sn); end
      4'd5:  begin mul_a = MUL_W'(sx); mul_b = MUL_W'(sn); end
      4'd6:  begin mul_a = MUL_W'(sy); mul_b = MUL_W'(cs); end
      4'd7:  begin mul_a = MUL_W'(dx); mul_b = MUL_W'(dx); end
      4'd9:  begin mul_a = MUL_W'(dy); mul_b = MUL_W'(dy); end
      4'd10: begin
        mul_a = MUL_W'(signed'({1'b0, rr}));
        mul_b = MUL_W'(signed'({1'b0, rr}));
      end
      default: begin end
    endcase
  end

  mcot_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      step      <= '0;
      hit       <= 1'b0;
      pad       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        pad <= pwdata[13:0];
      end
      // In ST_DONE the result register is either reloaded or still held.
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          step <= '0;
          idx  <= '0;
          hit  <= 1'b0;
          if (in_xfer) begin
            cx    <= center_x;
            cy    <= center_y;
            cs    <= rot_cos;
            sn    <= rot_sin;
            sc    <= scale;
            px    <= probe_x;
            py    <= probe_y;
            extra <= 15'(pad) + (probe_radius[13] ? 15'd0 : 15'(probe_radius));
            state <= ST_DONE;
            unique case (op_t'(opcode))
              OP_CLEAR:  count <= '0;
              OP_APPEND: begin
                if (count < CNT_W'(MAX_CIRCLES)) begin
                  count <= count + CNT_W'(1);
                end
              end
              OP_QUERY:  if (count != '0) state <= ST_READ;
              OP_NONE:   begin end
            endcase
          end
        end
        ST_READ: begin
          step  <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          step <= step + 4'd1;
          unique case (step)
            4'd1:  sx <= prod[26:0];
            4'd2:  sy <= prod[26:0];
            4'd3:  rr <= prod[25:0] + {3'd0, extra, 8'd0};
            4'd4:  acc <= 57'(prod);
            4'd5:  qx <= round_q4(acc - 57'(prod));
            4'd6:  begin
              acc <= 57'(prod);
              dx  <= 23'(cx) + 23'(qx) - 23'(px);
            end
            4'd7:  qy <= round_q4(acc + 57'(prod));
            4'd8:  begin
              acc <= 57'(prod);
              dy  <= 23'(cy) + 23'(qy) - 23'(py);
            end
            4'd10: acc <= acc + 57'(prod);
            4'd11: begin
              // Touching counts as overlap: squared distance scaled to match R.
              if ({acc[43:0], 16'd0} <= 60'(prod[51:0])) begin
                hit   <= 1'b1;
                state <= ST_DONE;
              end else if (last) begin
                state <= ST_DONE;
              end else begin
                idx   <= idx + IDX_W'(1);
                state <= ST_READ;
              end
            end
            default: begin end
          endcase
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            overlap      <= hit;
            circle_count <= 4'(count);
            state        <= ST_IDLE;
          end
        end
      endcase
    end
  end

  `include "multi_circle_overlap_test_assert.svh"

  `MCOT_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(MAX_CIRCLES))
  `MCOT_ASSERT_NEXT(a_clear_empties, in_xfer && op_t'(opcode) == OP_CLEAR, count == '0)
  `MCOT_ASSERT_NEXT(a_append_grows,
    in_xfer && op_t'(opcode) == OP_APPEND && count < CNT_W'(MAX_CIRCLES),
    count == $past(count) + CNT_W'(1))
  `MCOT_ASSERT_NOW(a_walk_in_table, state == ST_MUL, CNT_W'(idx) < count)
endmodule

// ----- tb/multi_circle_overlap_test_tb.sv -----
// Self-checking testbench for the multi-circle overlap test block.
// Depends on mcot_pkg and the multi_circle_overlap_test RTL; it predicts every
// result in its own model of the circle table and compares it field by field.
module multi_circle_overlap_test_tb;
  import mcot_pkg::*;

  localparam int TABLE_DEPTH = 8;
  localparam int ADDR_PAD = 0;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    op_t op;
    logic signed [14:0] ox, oy;
    logic [13:0] rad;
    logic signed [19:0] cx, cy;
    logic signed [15:0] cs, sn;
    logic [11:0] sc;
    logic signed [19:0] px, py;
    logic signed [13:0] pr;
  } circle_item_t;

  typedef struct {
    logic hit;
    logic [3:0] count;
  } overlap_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = '0;
  logic signed [14:0] circle_offset_x = '0, circle_offset_y = '0;
  logic [13:0] circle_radius = '0;
  logic signed [19:0] center_x = '0, center_y = '0;
  logic signed [15:0] rot_cos = '0, rot_sin = '0;
  logic [11:0] scale = '0;
  logic signed [19:0] probe_x = '0, probe_y = '0;
  logic signed [13:0] probe_radius = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic overlap;
  logic [3:0] circle_count;

  multi_circle_overlap_test dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: the stored circles, their count and the padding register.
  logic signed [14:0] tab_x [TABLE_DEPTH];
  logic signed [14:0] tab_y [TABLE_DEPTH];
  logic [13:0] tab_r [TABLE_DEPTH];
  int unsigned held;
  logic [13:0] pad_value;

  overlap_result_t pending_results[$];
  int errors, sent, received, hits_seen, idle_cycles;
  int stall_left;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH result %0d: %s got %0d expected %0d", received, what, got, want);
    errors++;
  endtask

  function automatic longint floor_div22(input longint v);
    return v >>> 22;  // arithmetic shift is a floor division
  endfunction

  function automatic logic circle_touches(input int i, input circle_item_t it);
    longint sx, sy, rx, ry, qx, qy, dx, dy, rr, pr;
    sx = longint'(tab_x[i]) * longint'(it.sc);
    sy = longint'(tab_y[i]) * longint'(it.sc);
    rx = sx * it.cs - sy * it.sn;
    ry = sx * it.sn + sy * it.cs;
    qx = floor_div22(rx + (64'sd1 <<< 21));
    qy = floor_div22(ry + (64'sd1 <<< 21));
    dx = it.cx + qx - it.px;
    dy = it.cy + qy - it.py;
    pr = it.pr < 0 ? 0 : longint'(it.pr);
    rr = longint'(tab_r[i]) * longint'(it.sc) + (longint'(pad_value) + pr) * 256;
    return ((dx * dx + dy * dy) <<< 16) <= rr * rr;
  endfunction

  function automatic overlap_result_t predict_overlap(input circle_item_t it);
    overlap_result_t res;
    res.hit = 1'b0;
    case (it.op)
      OP_CLEAR: held = 0;
      OP_APPEND: begin
        if (held < TABLE_DEPTH) begin
          tab_x[held] = it.ox < -8192 ? -15'sd8192 : (it.ox > 8192 ? 15'sd8192 : it.ox);
          tab_y[held] = it.oy < -8192 ? -15'sd8192 : (it.oy > 8192 ? 15'sd8192 : it.oy);
          tab_r[held] = it.rad < RAD_MIN ? RAD_MIN : (it.rad > RAD_MAX ? RAD_MAX : it.rad);
          held++;
        end
      end
      OP_QUERY: begin
        for (int i = 0; i < held; i++)
          if (!res.hit && circle_touches(i, it)) res.hit = 1'b1;
      end
      default: ;
    endcase
    res.count = held[3:0];
    return res;
  endfunction

  // Result checker. After each result transfer the output side draws how many
  // cycles it holds off the next result.
  always @(posedge clk) begin
    overlap_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected transfer", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (overlap !== want.hit) report_mismatch("overlap", overlap, want.hit);
          if (circle_count !== want.count)
            report_mismatch("circle_count", circle_count, want.count);
          if (want.hit) hits_seen++;
        end
        received++;
        stall_left = $urandom_range(0, 15);
      end else if (out_valid && stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog: counts cycles in which neither channel moves a transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("multi_circle_overlap_test regression: fail");
      $finish;
    end
  end

  // Valid stays high into the next item when there is no gap; it drops only
  // before a gap or when the sender drains.
  task automatic send_item(input circle_item_t it, input bit gaps);
    int wait_cycles;
    wait_cycles = gaps ? $urandom_range(0, 15) : 0;
    if (wait_cycles > 0) begin
      in_valid <= 1'b0;
      repeat (wait_cycles) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= it.op;
    circle_offset_x <= it.ox;
    circle_offset_y <= it.oy;
    circle_radius <= it.rad;
    center_x <= it.cx;
    center_y <= it.cy;
    rot_cos <= it.cs;
    rot_sin <= it.sn;
    scale <= it.sc;
    probe_x <= it.px;
    probe_y <= it.py;
    probe_radius <= it.pr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results = {pending_results, predict_overlap(it)};
    sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pad(input logic [13:0] value);
    drain_results();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'(ADDR_PAD);
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pad_value = value;
  endtask

  function automatic circle_item_t random_item(input op_t op);
    circle_item_t it;
    it.op = op;
    it.ox = 15'($urandom);
    it.oy = 15'($urandom);
    it.rad = 14'($urandom);
    it.cx = 20'($urandom);
    it.cy = 20'($urandom);
    it.cs = 16'($urandom_range(0, 32768) - 16384);
    it.sn = 16'($urandom_range(0, 32768) - 16384);
    it.sc = 12'($urandom);
    it.px = 20'($urandom);
    it.py = 20'($urandom);
    it.pr = 14'($urandom);
    return it;
  endfunction

  // A query placed near the profile so that hits and misses both occur.
  function automatic circle_item_t near_query();
    circle_item_t it;
    int ang;
    it = random_item(OP_QUERY);
    it.cx = 20'($urandom_range(0, 8000) - 4000);
    it.cy = 20'($urandom_range(0, 8000) - 4000);
    it.px = it.cx + 20'($urandom_range(0, 16000) - 8000);
    it.py = it.cy + 20'($urandom_range(0, 16000) - 8000);
    it.sc = 12'($urandom_range(64, 512));
    ang = $urandom_range(0, 3);
    it.cs = (ang == 0) ? 16'sd16384 : (ang == 1) ? -16'sd16384 : 16'sd11585;
    it.sn = (ang >= 2) ? 16'sd11585 : 16'sd0;
    if ($urandom_range(0, 3) == 0) it.pr = -14'($urandom_range(1, 8192));
    return it;
  endfunction

  task automatic test_directed();
    circle_item_t it;
    it = random_item(OP_QUERY);
    send_item(it, 0);                    // query on an empty table
    it = random_item(OP_APPEND);
    it.ox = -15'sd16384; it.oy = 15'sd16383; it.rad = 14'd0;
    send_item(it, 0);
    it.ox = 15'sd16383; it.oy = -15'sd16384; it.rad = 14'd16383;
    send_item(it, 0);
    it.ox = 15'sd0; it.oy = 15'sd0; it.rad = 14'd100;
    repeat (6) send_item(it, 0);         // fills the table, last append takes the last slot
    it = near_query();
    it.cs = 16'sd16384; it.sn = -16'sd16384; it.sc = 12'd4095;
    it.px = it.cx; it.py = it.cy;
    send_item(it, 0);                    // exact hit at the center
    it = random_item(OP_QUERY);
    it.cx = 20'sh80000; it.cy = 20'sh7FFFF; it.px = 20'sh7FFFF; it.py = 20'sh80000;
    it.pr = 14'sh1FFF; it.sc = 12'd0;
    send_item(it, 0);
    it.pr = 14'sh2000; it.cs = 16'sd20000; it.sn = -16'sd30000;
    send_item(it, 0);                    // out-of-range rotation and negative probe
    send_item(random_item(OP_NONE), 0);
    send_item(random_item(OP_CLEAR), 0);
    send_item(random_item(OP_QUERY), 0);
  endtask

  task automatic test_pad_settings();
    circle_item_t it;
    logic [13:0] pads [4] = '{14'd8192, 14'd0, 14'd16383, 14'd37};
    foreach (pads[k]) begin
      write_pad(pads[k]);
      send_item(random_item(OP_CLEAR), 1);
      repeat (3) begin
        it = random_item(OP_APPEND);
        it.ox = 15'($urandom_range(0, 4000) - 2000);
        it.oy = 15'($urandom_range(0, 4000) - 2000);
        send_item(it, 1);
      end
      repeat (4) send_item(near_query(), 1);
    end
  endtask

  task automatic test_random_traffic();
    circle_item_t it;
    int roll;
    for (int n = 0; n < 360; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) it = random_item(OP_CLEAR);
      else if (roll < 40) begin
        it = random_item(OP_APPEND);
        if ($urandom_range(0, 3) != 0) begin
          it.ox = 15'($urandom_range(0, 6000) - 3000);
          it.oy = 15'($urandom_range(0, 6000) - 3000);
        end
      end else if (roll < 85) it = near_query();
      else if (roll < 95) it = random_item(OP_QUERY);
      else it = random_item(OP_NONE);
      send_item(it, n % 60 < 45);
      if (n == 180) begin
        drain_results();                 // sender holds off until all results arrive
        write_pad(14'($urandom_range(0, 8192)));
      end
    end
  endtask

  initial begin
    held = 0;
    pad_value = '0;
    stall_left = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_pad_settings();
    test_random_traffic();
    drain_results();
    repeat (200) @(posedge clk);
    $display("Sent %0d items, checked %0d results, %0d overlaps, %0d errors.",
             sent, received, hits_seen, errors);
    if (errors == 0 && pending_results.size() == 0)
      $display("multi_circle_overlap_test regression: pass");
    else
      $display("multi_circle_overlap_test regression: fail");
    $finish;
  end
endmodule
